FILE: hw/rtl/budgeted_round_robin_drain_core_assert.svh
// Assertion macros for the budgeted round-robin drain core.
`ifndef BUDGETED_ROUND_ROBIN_DRAIN_CORE_ASSERT_SVH
`define BUDGETED_ROUND_ROBIN_DRAIN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BRRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRRD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define BRRD_ASSERT(label, prop, msg)
`define BRRD_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

FILE: hw/rtl/brrd_pkg.sv
// Package with types and constants of the budgeted round-robin drain core.
`timescale 1ns / 1ps

package brrd_pkg;

    localparam int MAX_QUEUES_DEFAULT = 8;
    localparam int QIDX_W = 3;
    localparam int CNT_W = 8;
    localparam int NQ_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [NQ_W-1:0] QUEUES_IN_USE_RST = 4'd8;
    localparam logic [CNT_W-1:0] ROUND_BUDGET_RST = 8'd64;
    localparam logic [CNT_W-1:0] PER_QUEUE_CAP_RST = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUES_IN_USE = 2'd0,
        REG_ROUND_BUDGET  = 2'd1,
        REG_PER_QUEUE_CAP = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_VISIT
    } state_t;

    function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: hw/rtl/brrd_if.sv
// Handshake channel interfaces of the budgeted round-robin drain core.
`timescale 1ns / 1ps

interface brrd_round_if;
    logic                          valid;
    logic                          ready;
    logic [brrd_pkg::CNT_W-1:0]    pending_q0;
    logic [brrd_pkg::CNT_W-1:0]    pending_q1;
    logic [brrd_pkg::CNT_W-1:0]    pending_q2;
    logic [brrd_pkg::CNT_W-1:0]    pending_q3;
    logic [brrd_pkg::CNT_W-1:0]    pending_q4;
    logic [brrd_pkg::CNT_W-1:0]    pending_q5;
    logic [brrd_pkg::CNT_W-1:0]    pending_q6;
    logic [brrd_pkg::CNT_W-1:0]    pending_q7;

    modport source (
        output valid, pending_q0, pending_q1, pending_q2, pending_q3,
               pending_q4, pending_q5, pending_q6, pending_q7,
        input  ready
    );
    modport sink (
        input  valid, pending_q0, pending_q1, pending_q2, pending_q3,
               pending_q4, pending_q5, pending_q6, pending_q7,
        output ready
    );
endinterface

interface brrd_grant_if;
    logic                          valid;
    logic                          ready;
    logic [brrd_pkg::QIDX_W-1:0]   queue_index;
    logic [brrd_pkg::CNT_W-1:0]    pop_count;
    logic                          last_grant;

    modport source (
        output valid, queue_index, pop_count, last_grant,
        input  ready
    );
    modport sink (
        input  valid, queue_index, pop_count, last_grant,
        output ready
    );
endinterface

interface brrd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [brrd_pkg::CFG_IDX_W-1:0]    index;
    logic [brrd_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: hw/rtl/budgeted_round_robin_drain_core.sv
// Top level of the budgeted round-robin drain core.
// A round is accepted in ST_IDLE; ST_NORM wraps the start queue into range by
// subtracting the queues in use, then ST_VISIT grants the visited queues one at a
// time while the output register is free. A new round is accepted only in ST_IDLE, as
// the grant sequencer handles one queue at a time through a single min/subtract unit.
// Asynchronous active-low reset restores the register defaults and start queue zero.
`timescale 1ns / 1ps

module budgeted_round_robin_drain_core #(
    parameter int MAX_QUEUES = brrd_pkg::MAX_QUEUES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    brrd_round_if.sink            in_round,
    brrd_grant_if.source          out_grant,
    brrd_cfg_if.sink              cfg
);

    `include "budgeted_round_robin_drain_core_assert.svh"

    localparam int QW = brrd_pkg::QIDX_W;
    localparam int CW = brrd_pkg::CNT_W;
    localparam int NW = brrd_pkg::NQ_W;

    brrd_pkg::state_t state_reg, state_next;

    logic [NW-1:0] queues_in_use_reg;
    logic [CW-1:0] round_budget_reg;
    logic [CW-1:0] per_queue_cap_reg;

    logic [QW-1:0] start_queue_reg, start_queue_next;
    logic [QW-1:0] q_reg, q_next;
    logic [NW-1:0] n_reg, n_next;
    logic [CW-1:0] used_reg, used_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    logic          out_valid_reg, out_valid_next;
    logic [QW-1:0] out_qidx_reg, out_qidx_next;
    logic [CW-1:0] out_pop_reg, out_pop_next;
    logic          out_last_reg, out_last_next;

    logic [CW-1:0] pend_reg [MAX_QUEUES];
    logic [CW-1:0] pend_in [8];

    logic          accept;
    logic          load;
    logic [NW-1:0] n_clamp;
    logic [NW-1:0] q_inc;
    logic [CW-1:0] pend_cur;
    logic [CW-1:0] remain;
    logic [CW-1:0] grant;
    logic          is_last;

    assign pend_in[0] = in_round.pending_q0;
    assign pend_in[1] = in_round.pending_q1;
    assign pend_in[2] = in_round.pending_q2;
    assign pend_in[3] = in_round.pending_q3;
    assign pend_in[4] = in_round.pending_q4;
    assign pend_in[5] = in_round.pending_q5;
    assign pend_in[6] = in_round.pending_q6;
    assign pend_in[7] = in_round.pending_q7;

    assign in_round.ready = (state_reg == brrd_pkg::ST_IDLE);
    assign accept = in_round.valid && in_round.ready;
    assign cfg.ready = 1'b1;

    assign out_grant.valid = out_valid_reg;
    assign out_grant.queue_index = out_qidx_reg;
    assign out_grant.pop_count = out_pop_reg;
    assign out_grant.last_grant = out_last_reg;

    always_comb
    begin
        if (queues_in_use_reg == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (queues_in_use_reg > NW'(MAX_QUEUES))
        begin
            n_clamp = NW'(MAX_QUEUES);
        end
        else
        begin
            n_clamp = queues_in_use_reg;
        end
    end

    always_comb
    begin
        pend_cur = '0;
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            if (q_reg == QW'(i))
            begin
                pend_cur = pend_reg[i];
            end
        end
    end

    // The shared unit: budget left, then the smallest of pending, cap and budget left.
    assign q_inc = {1'b0, q_reg} + NW'(1);
    assign remain = round_budget_reg - used_reg;
    assign grant = brrd_pkg::min_cnt(pend_cur, brrd_pkg::min_cnt(per_queue_cap_reg, remain));
    assign is_last = ((cnt_reg + NW'(1)) == n_reg) ||
                     (({1'b0, used_reg} + {1'b0, grant}) >= {1'b0, round_budget_reg});

    always_comb
    begin
        state_next = state_reg;
        start_queue_next = start_queue_reg;
        q_next = q_reg;
        n_next = n_reg;
        used_next = used_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_grant.ready;
        out_qidx_next = out_qidx_reg;
        out_pop_next = out_pop_reg;
        out_last_next = out_last_reg;
        load = 1'b0;

        case (state_reg)
            brrd_pkg::ST_IDLE:
            begin
                if (in_round.valid)
                begin
                    state_next = brrd_pkg::ST_NORM;
                    q_next = start_queue_reg;
                    n_next = n_clamp;
                    used_next = '0;
                    cnt_next = '0;
                end
            end
            brrd_pkg::ST_NORM:
            begin
                if ({1'b0, q_reg} >= n_reg)
                begin
                    q_next = QW'({1'b0, q_reg} - n_reg);
                end
                else
                begin
                    start_queue_next = (q_inc == n_reg) ? '0 : q_inc[QW-1:0];
                    if (round_budget_reg == '0)
                    begin
                        state_next = brrd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = brrd_pkg::ST_VISIT;
                    end
                end
            end
            brrd_pkg::ST_VISIT:
            begin
                if (!out_valid_reg || out_grant.ready)
                begin
                    load = 1'b1;
                    out_valid_next = 1'b1;
                    out_qidx_next = q_reg;
                    out_pop_next = grant;
                    out_last_next = is_last;
                    used_next = used_reg + grant;
                    cnt_next = cnt_reg + NW'(1);
                    q_next = (q_inc == n_reg) ? '0 : q_inc[QW-1:0];
                    if (is_last)
                    begin
                        state_next = brrd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = brrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brrd_pkg::ST_IDLE;
            start_queue_reg <= '0;
            q_reg <= '0;
            n_reg <= '0;
            used_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_queue_reg <= start_queue_next;
            q_reg <= q_next;
            n_reg <= n_next;
            used_reg <= used_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_qidx_reg <= out_qidx_next;
        out_pop_reg <= out_pop_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                pend_reg[i] <= pend_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queues_in_use_reg <= brrd_pkg::QUEUES_IN_USE_RST;
            round_budget_reg <= brrd_pkg::ROUND_BUDGET_RST;
            per_queue_cap_reg <= brrd_pkg::PER_QUEUE_CAP_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (brrd_pkg::cfg_reg_t'(cfg.index))
                brrd_pkg::REG_QUEUES_IN_USE:
                begin
                    queues_in_use_reg <= cfg.data[NW-1:0];
                end
                brrd_pkg::REG_ROUND_BUDGET:
                begin
                    round_budget_reg <= cfg.data;
                end
                brrd_pkg::REG_PER_QUEUE_CAP:
                begin
                    per_queue_cap_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    `BRRD_ASSERT(a_visits_bounded, (state_reg == brrd_pkg::ST_IDLE) || (cnt_reg < n_reg), "visit count reached the queues in use")
    `BRRD_ASSERT_NEXT(a_stall_holds, (state_reg == brrd_pkg::ST_VISIT) && out_valid_reg && !out_grant.ready, $stable(q_reg) && $stable(used_reg) && out_valid_reg, "round advanced while the output was stalled")
    `BRRD_ASSERT_NEXT(a_last_ends_round, load && out_last_next, (state_reg == brrd_pkg::ST_IDLE) && out_grant.last_grant, "last grant did not close the round")

endmodule

FILE: tb/sv/testbench.sv
// Testbench of the budgeted round-robin drain core, checking every grant against expected grants.
`timescale 1ns / 1ps

module testbench;

    localparam int QW = brrd_pkg::QIDX_W;
    localparam int CW = brrd_pkg::CNT_W;
    localparam int NW = brrd_pkg::NQ_W;
    localparam int IW = brrd_pkg::CFG_IDX_W;
    localparam int DW = brrd_pkg::CFG_DATA_W;

    localparam int QUEUE_SLOTS = brrd_pkg::MAX_QUEUES_DEFAULT;
    localparam int DIRECTED_ROWS = 29;
    localparam int RANDOM_PHASES = 6;
    localparam int ROUNDS_PER_PHASE = 25;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER = 55;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [IW-1:0] REG_SPARE = 2'd3;

    typedef logic [QUEUE_SLOTS-1:0][CW-1:0] pending_t;

    typedef struct {
        logic [QW-1:0] queue_index;
        logic [CW-1:0] pop_count;
        logic          last_grant;
    } grant_t;

    typedef enum logic {
        ROW_ROUND,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [IW-1:0] reg_index;
        logic [DW-1:0] value;
        pending_t      pending;
        logic          known;
        logic [3:0]    n_grants;
        logic [QW-1:0] first_queue;
        logic [3:0]    ring_size;
        logic [CW-1:0] pop;
    } row_t;

    logic clk;
    logic rst_n;

    brrd_round_if round_ch ();
    brrd_grant_if grant_ch ();
    brrd_cfg_if   cfg_ch ();

    budgeted_round_robin_drain_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_round  (round_ch),
        .out_grant (grant_ch),
        .cfg       (cfg_ch)
    );

    logic [NW-1:0] ring_setting = brrd_pkg::QUEUES_IN_USE_RST;
    logic [CW-1:0] budget_setting = brrd_pkg::ROUND_BUDGET_RST;
    logic [CW-1:0] cap_setting = brrd_pkg::PER_QUEUE_CAP_RST;
    logic [QW-1:0] next_start = '0;

    grant_t expected_grants [$];
    grant_t round_plan [$];
    int     errors = 0;
    int     rounds_accepted = 0;
    int     burst_left = 0;

    // Rows with a known shape expect n_grants grants of equal pop count, walking the ring
    // from first_queue; the remaining rows are checked against the round planner.
    row_t directed [DIRECTED_ROWS] = '{
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h0000000000000000,
          1'b1, 4'd8, 3'd0, 4'd8, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'hFFFFFFFFFFFFFFFF,
          1'b1, 4'd4, 3'd1, 4'd8, 8'd16},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h0102030405060708,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h55AA55AA55AA55AA,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_PER_QUEUE_CAP, 8'h00, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'hFFFFFFFFFFFFFFFF,
          1'b1, 4'd8, 3'd4, 4'd8, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_PER_QUEUE_CAP, 8'hFF, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_ROUND_BUDGET,  8'hFF, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'hFFFFFFFFFFFFFFFF,
          1'b1, 4'd1, 3'd5, 4'd8, 8'd255},
        '{ROW_WRITE, brrd_pkg::REG_ROUND_BUDGET,  8'h00, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h8040201008040201,
          1'b1, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_ROUND_BUDGET,  8'hFF, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h00000000000000AA,
          1'b1, 4'd1, 3'd0, 4'd1, 8'hAA},
        '{ROW_WRITE, brrd_pkg::REG_QUEUES_IN_USE, 8'hFF, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h0102040810204080,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_QUEUES_IN_USE, 8'h05, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_ROUND_BUDGET,  8'd40, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_PER_QUEUE_CAP, 8'd12, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h0A0A0A0A0A0A0A0A,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'hFF00FF0000FF00FF,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_QUEUES_IN_USE, 8'h03, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'h112233445566778A,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, REG_SPARE,                   8'h00, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_ROUND, brrd_pkg::REG_QUEUES_IN_USE, 8'h00, 64'hFFFFFFFFFFFFFFFF,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_QUEUES_IN_USE, 8'h08, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_ROUND_BUDGET,  8'd64, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0},
        '{ROW_WRITE, brrd_pkg::REG_PER_QUEUE_CAP, 8'd16, 64'h0000000000000000,
          1'b0, 4'd0, 3'd0, 4'd0, 8'd0}
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void plan_grants(input pending_t pend);
        int     ring;
        int     first;
        int     spent;
        int     q;
        int     share;
        grant_t g;
        round_plan.delete();
        if (ring_setting == 0)
        begin
            ring = 1;
        end
        else if (ring_setting > QUEUE_SLOTS)
        begin
            ring = QUEUE_SLOTS;
        end
        else
        begin
            ring = int'(ring_setting);
        end
        first = int'(next_start) % ring;
        spent = 0;
        for (int k = 0; k < ring && spent < int'(budget_setting); k++)
        begin
            q = (first + k) % ring;
            share = int'(pend[q]);
            if (int'(cap_setting) < share)
            begin
                share = int'(cap_setting);
            end
            if (int'(budget_setting) - spent < share)
            begin
                share = int'(budget_setting) - spent;
            end
            spent += share;
            g.queue_index = QW'(q);
            g.pop_count = CW'(share);
            g.last_grant = 1'b0;
            round_plan.push_back(g);
        end
        if (round_plan.size() > 0)
        begin
            round_plan[round_plan.size() - 1].last_grant = 1'b1;
        end
        next_start = QW'((first + 1) % ring);
    endfunction

    function automatic pending_t random_pending();
        pending_t pend;
        for (int q = 0; q < QUEUE_SLOTS; q++)
        begin
            case ($urandom_range(0, 7))
                0, 1:    pend[q] = '0;
                2:       pend[q] = '1;
                3, 4:    pend[q] = CW'($urandom_range(1, 20));
                default: pend[q] = CW'($urandom);
            endcase
        end
        return pend;
    endfunction

    function automatic logic [DW-1:0] random_limit();
        case ($urandom_range(0, 11))
            0:       return 8'd1;
            1:       return 8'd255;
            2:       return 8'd0;
            3, 4, 5: return DW'($urandom_range(1, 16));
            default: return DW'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_round(input pending_t pend, input logic known, input int n_grants,
                              input int first_queue, input int ring_size,
                              input logic [CW-1:0] pop);
        grant_t g;
        @(negedge clk);
        round_ch.valid <= 1'b1;
        round_ch.pending_q0 <= pend[0];
        round_ch.pending_q1 <= pend[1];
        round_ch.pending_q2 <= pend[2];
        round_ch.pending_q3 <= pend[3];
        round_ch.pending_q4 <= pend[4];
        round_ch.pending_q5 <= pend[5];
        round_ch.pending_q6 <= pend[6];
        round_ch.pending_q7 <= pend[7];
        do
        begin
            @(posedge clk);
        end
        while (round_ch.ready !== 1'b1);
        rounds_accepted++;
        plan_grants(pend);
        if (known)
        begin
            for (int k = 0; k < n_grants; k++)
            begin
                g.queue_index = QW'((first_queue + k) % ring_size);
                g.pop_count = pop;
                g.last_grant = (k == n_grants - 1);
                expected_grants.push_back(g);
            end
        end
        else
        begin
            foreach (round_plan[i])
            begin
                expected_grants.push_back(round_plan[i]);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            @(negedge clk);
            round_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        @(negedge clk);
        round_ch.valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            brrd_pkg::REG_QUEUES_IN_USE: ring_setting = val[NW-1:0];
            brrd_pkg::REG_ROUND_BUDGET:  budget_setting = val;
            brrd_pkg::REG_PER_QUEUE_CAP: cap_setting = val;
            default:                     ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    initial
    begin
        row_t r;
        rst_n = 1'b0;
        round_ch.valid = 1'b0;
        round_ch.pending_q0 = '0;
        round_ch.pending_q1 = '0;
        round_ch.pending_q2 = '0;
        round_ch.pending_q3 = '0;
        round_ch.pending_q4 = '0;
        round_ch.pending_q5 = '0;
        round_ch.pending_q6 = '0;
        round_ch.pending_q7 = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = brrd_pkg::REG_QUEUES_IN_USE;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        burst_left = $urandom_range(0, 15);

        foreach (directed[i])
        begin
            r = directed[i];
            if (r.kind == ROW_WRITE)
            begin
                write_reg(r.reg_index, r.value);
            end
            else
            begin
                send_round(r.pending, r.known, r.n_grants, r.first_queue, r.ring_size, r.pop);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(brrd_pkg::REG_QUEUES_IN_USE, 8'h01);
                write_reg(brrd_pkg::REG_ROUND_BUDGET, 8'd1);
                write_reg(brrd_pkg::REG_PER_QUEUE_CAP, random_limit());
            end
            else if (phase == 1)
            begin
                write_reg(brrd_pkg::REG_QUEUES_IN_USE, 8'hF8);
                write_reg(brrd_pkg::REG_ROUND_BUDGET, 8'd255);
                write_reg(brrd_pkg::REG_PER_QUEUE_CAP, 8'd1);
            end
            else
            begin
                write_reg(brrd_pkg::REG_QUEUES_IN_USE, DW'($urandom));
                write_reg(brrd_pkg::REG_ROUND_BUDGET, random_limit());
                write_reg(brrd_pkg::REG_PER_QUEUE_CAP, random_limit());
                if ($urandom_range(0, 2) == 0)
                begin
                    write_reg(REG_SPARE, DW'($urandom));
                end
            end
            repeat (ROUNDS_PER_PHASE)
            begin
                send_round(random_pending(), 1'b0, 0, 0, 0, '0);
            end
        end

        @(negedge clk);
        round_ch.valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        int stretch;
        int style;
        bit pressure_done;
        grant_ch.ready = 1'b0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch = $urandom_range(4, 40);
            style = $urandom_range(0, 2);
            repeat (stretch)
            begin
                @(negedge clk);
                if (!pressure_done && rounds_accepted >= HOLD_OFF_AFTER)
                begin
                    // Hold the grant channel off long enough for the core to back up.
                    grant_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                    pressure_done = 1'b1;
                end
                else
                begin
                    case (style)
                        0:       grant_ch.ready <= 1'b1;
                        1:       grant_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: grant_ch.ready <= ($urandom_range(0, 2) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        grant_t want;
        forever
        begin
            @(posedge clk);
            if (grant_ch.valid === 1'b1 && grant_ch.ready === 1'b1)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: grant expected none actual queue_index %0d pop_count %0d last_grant %0b",
                             $time, grant_ch.queue_index, grant_ch.pop_count, grant_ch.last_grant);
                    errors++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    check_field("queue_index", CW'(want.queue_index),
                                CW'(grant_ch.queue_index));
                    check_field("pop_count", want.pop_count, grant_ch.pop_count);
                    check_field("last_grant", CW'(want.last_grant),
                                CW'(grant_ch.last_grant));
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((round_ch.valid === 1'b1 && round_ch.ready === 1'b1) ||
                (grant_ch.valid === 1'b1 && grant_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule
